FILE: hdl/bsbm_pkg.sv
// Shared types and constants for the board square to gantry step mapper.
// No dependencies; used by every module of the block.
package bsbm_pkg;

    localparam int CW   = 24;            // coordinate width
    localparam int NREG = 8;             // corner registers
    localparam int AW   = 5;             // APB byte address width

    // Register indexes
    localparam int REG_A1_X = 0;
    localparam int REG_A1_Y = 1;
    localparam int REG_H1_X = 2;
    localparam int REG_H1_Y = 3;
    localparam int REG_A8_X = 4;
    localparam int REG_A8_Y = 5;
    localparam int REG_H8_X = 6;
    localparam int REG_H8_Y = 7;

    // Direction codes
    localparam logic [1:0] DIR_NEG = 2'b11;
    localparam logic [1:0] DIR_POS = 2'b01;

    // Travel limits and edge handling
    localparam int X_MIN       = 0;
    localparam int X_MAX       = 65535;
    localparam int Y_MIN       = 0;
    localparam int Y_MAX       = 65535;
    localparam int EDGE_STOP   = 100;
    localparam int EDGE_MARGIN = 200;

    localparam int QW  = $clog2(EDGE_MARGIN + 1);   // push amount bits
    localparam int DW  = CW + 1;                    // centre minus edge
    localparam int D2W = 2 * CW + 1;                // squared difference
    localparam int SW  = D2W + 1;                   // sum of squares
    localparam int SHW = SW / 2;                    // half of s for split multiply
    localparam int K2W = 2 * (QW + 1);              // (2q-1)^2
    localparam int MW  = K2W;                       // 4*margin^2 width
    localparam int W2W = D2W + MW;                  // (2|d|margin)^2
    localparam int PW  = K2W + SW;                  // (2q-1)^2 * s

    localparam logic [MW-1:0] M2X4 = MW'(4 * EDGE_MARGIN * EDGE_MARGIN);

    localparam logic signed [26:0] X_LO_LIM = 27'(X_MIN + EDGE_STOP);
    localparam logic signed [26:0] X_HI_LIM = 27'(X_MAX - EDGE_STOP);
    localparam logic signed [26:0] Y_LO_LIM = 27'(Y_MIN + EDGE_STOP);
    localparam logic signed [26:0] Y_HI_LIM = 27'(Y_MAX - EDGE_STOP);
    localparam logic signed [26:0] SAT_LO   = -27'sd8388608;
    localparam logic signed [26:0] SAT_HI   = 27'sd8388607;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [NREG-1:0][CW-1:0] corner_vec_t;

    // Interpolated points: edge (e) and centre (c)
    typedef struct packed {
        logic   op;
        coord_t ex;
        coord_t ey;
        coord_t cx;
        coord_t cy;
    } pts_t;

    // One axis of the inward push search
    typedef struct packed {
        logic           push;
        logic           neg;
        coord_t         e;
        logic [SW-1:0]  s;
        logic [W2W-1:0] w2;
        logic [QW-1:0]  lo;
        logic [K2W-1:0] a2;     // (2*lo-1)^2
    } srch_t;

    function automatic coord_t clamp_out(logic signed [25:0] v,
                                         logic signed [26:0] lo,
                                         logic signed [26:0] hi);
        logic signed [26:0] w;
        logic signed [26:0] r;
        w = 27'(v);
        if (w < lo) begin
            r = lo;
        end else if (w > hi) begin
            r = hi;
        end else begin
            r = w;
        end
        if (r < SAT_LO) begin
            r = SAT_LO;
        end
        if (r > SAT_HI) begin
            r = SAT_HI;
        end
        return coord_t'(r[CW-1:0]);
    endfunction

endpackage

FILE: hdl/bsbm_regs.sv
// APB corner register file for the board square mapper.
// Depends on bsbm_pkg.
module bsbm_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsbm_pkg::AW-1:0]    paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output bsbm_pkg::corner_vec_t      corners
);

    bsbm_pkg::corner_vec_t corner_reg;
    logic [2:0]            idx;

    assign idx     = paddr[bsbm_pkg::AW-1:2];
    assign pready  = 1'b1;
    assign corners = corner_reg;
    assign prdata  = {{(32 - bsbm_pkg::CW){corner_reg[idx][bsbm_pkg::CW-1]}}, corner_reg[idx]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg <= '0;
        end else if (psel && penable && pwrite) begin
            corner_reg[idx] <= pwdata[bsbm_pkg::CW-1:0];
        end
    end

endmodule

FILE: hdl/bsbm_interp.sv
// Three-stage bilinear interpolation of the edge point and the square centre.
// Depends on bsbm_pkg.
module bsbm_interp (
    input  logic                  aclk,
    input  logic                  en_w,
    input  logic                  en_p,
    input  logic                  en_r,
    input  logic                  op_in,
    input  logic [2:0]            file_in,
    input  logic [3:0]            rank_in,
    input  logic [1:0]            dir_x_in,
    input  logic [1:0]            dir_y_in,
    input  bsbm_pkg::corner_vec_t corners,
    output bsbm_pkg::pts_t        pts_reg
);

    function automatic logic [4:0] clip16(logic [5:0] t);
        return (t > 6'd16) ? 5'd16 : t[4:0];
    endfunction

    function automatic bsbm_pkg::coord_t round256(logic signed [35:0] n);
        logic signed [35:0] m;
        if (n >= 0) begin
            m = (n + 36'sd128) >>> 8;
        end else begin
            m = -((-n + 36'sd128) >>> 8);
        end
        return bsbm_pkg::coord_t'(m);
    endfunction

    logic [5:0] r2;
    logic [4:0] uc, vc, ue, ve;
    logic [4:0] pu [2];
    logic [4:0] pv [2];
    logic [8:0] wt_next [2][4];

    logic [8:0]         wt_reg  [2][4];
    logic               op1_reg, op2_reg;
    logic signed [33:0] prd_reg [2][2][4];
    bsbm_pkg::pts_t     pts_next;
    logic signed [35:0] nsum [2][2];

    // Stage 1: positions in half squares and weights
    always_comb begin
        r2 = {1'b0, rank_in, 1'b0};
        uc = {1'b0, file_in, 1'b0} + 5'd1;
        vc = (rank_in == 4'd0) ? 5'd0 : clip16(r2 - 6'd1);
        ue = uc;
        ve = vc;
        if (dir_x_in == bsbm_pkg::DIR_NEG) begin
            ue = {1'b0, file_in, 1'b0};
        end else if (dir_x_in == bsbm_pkg::DIR_POS) begin
            ue = {1'b0, file_in, 1'b0} + 5'd2;
        end
        if (dir_y_in == bsbm_pkg::DIR_NEG) begin
            ve = (rank_in == 4'd0) ? 5'd0 : clip16(r2 - 6'd2);
        end else if (dir_y_in == bsbm_pkg::DIR_POS) begin
            ve = clip16(r2);
        end
        pu[0] = uc;
        pv[0] = vc;
        pu[1] = ue;
        pv[1] = ve;
        for (int p = 0; p < 2; p++) begin
            wt_next[p][0] = 9'(5'd16 - pu[p]) * 9'(5'd16 - pv[p]);
            wt_next[p][1] = 9'(pu[p]) * 9'(5'd16 - pv[p]);
            wt_next[p][2] = 9'(5'd16 - pu[p]) * 9'(pv[p]);
            wt_next[p][3] = 9'(pu[p]) * 9'(pv[p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_w) begin
            wt_reg  <= wt_next;
            op1_reg <= op_in;
        end
    end

    // Stage 2: weight times corner; corner j axis a sits at register 2j+a
    always_ff @(posedge aclk) begin
        if (en_p) begin
            op2_reg <= op1_reg;
            for (int p = 0; p < 2; p++) begin
                for (int a = 0; a < 2; a++) begin
                    for (int j = 0; j < 4; j++) begin
                        prd_reg[p][a][j] <= $signed(corners[2*j+a]) *
                                            $signed({1'b0, wt_reg[p][j]});
                    end
                end
            end
        end
    end

    // Stage 3: sum and round to steps
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            for (int a = 0; a < 2; a++) begin
                nsum[p][a] = 36'(prd_reg[p][a][0]) + 36'(prd_reg[p][a][1])
                           + 36'(prd_reg[p][a][2]) + 36'(prd_reg[p][a][3]);
            end
        end
        pts_next.op = op2_reg;
        pts_next.cx = round256(nsum[0][0]);
        pts_next.cy = round256(nsum[0][1]);
        pts_next.ex = round256(nsum[1][0]);
        pts_next.ey = round256(nsum[1][1]);
    end

    always_ff @(posedge aclk) begin
        if (en_r) begin
            pts_reg <= pts_next;
        end
    end

endmodule

FILE: hdl/bsbm_step.sv
// One bit of the inward push search for one axis, two register stages:
// candidate square times s, then compare and keep.
// Depends on bsbm_pkg.
module bsbm_step #(
    parameter int B = 0
) (
    input  logic            aclk,
    input  logic            en_a,
    input  logic            en_b,
    input  bsbm_pkg::srch_t d_in,
    output bsbm_pkg::srch_t d_reg
);

    localparam int KW  = bsbm_pkg::K2W + 2;
    localparam int HW  = bsbm_pkg::K2W + bsbm_pkg::SW - bsbm_pkg::SHW;
    localparam int AQW = bsbm_pkg::QW + 2;

    logic [bsbm_pkg::QW-1:0]       cand;
    logic signed [bsbm_pkg::QW+1:0] a;
    logic signed [KW-1:0]          k2w;
    logic [bsbm_pkg::K2W-1:0]      k2;

    bsbm_pkg::srch_t               mid_reg;
    logic [bsbm_pkg::QW-1:0]       cand_reg;
    logic [bsbm_pkg::K2W-1:0]      k2_reg;
    logic                          ok_reg;
    logic [HW-1:0]                 plo_reg;
    logic [HW-1:0]                 phi_reg;
    logic [bsbm_pkg::PW-1:0]       prod;
    bsbm_pkg::srch_t               d_next;

    // (2*cand-1)^2 from (2*lo-1)^2 by shifts and adds
    always_comb begin
        cand = d_in.lo | (bsbm_pkg::QW'(1) << B);
        a    = $signed({1'b0, d_in.lo, 1'b0}) - $signed(AQW'(1));
        k2w  = $signed({2'b00, d_in.a2}) + (KW'(a) <<< (B + 2))
             + (KW'(1) <<< (2 * B + 2));
        k2   = k2w[bsbm_pkg::K2W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            mid_reg  <= d_in;
            cand_reg <= cand;
            k2_reg   <= k2;
            ok_reg   <= (cand <= bsbm_pkg::QW'(bsbm_pkg::EDGE_MARGIN));
            plo_reg  <= HW'(k2) * HW'(d_in.s[bsbm_pkg::SHW-1:0]);
            phi_reg  <= HW'(k2) * HW'(d_in.s[bsbm_pkg::SW-1:bsbm_pkg::SHW]);
        end
    end

    always_comb begin
        prod   = (bsbm_pkg::PW'(phi_reg) << bsbm_pkg::SHW) + bsbm_pkg::PW'(plo_reg);
        d_next = mid_reg;
        if (ok_reg && (prod <= bsbm_pkg::PW'(mid_reg.w2))) begin
            d_next.lo = cand_reg;
            d_next.a2 = k2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            d_reg <= d_next;
        end
    end

endmodule

FILE: hdl/board_square_bilinear_map.sv
// Board square to gantry step mapper, top level.
// Depends on bsbm_pkg, bsbm_regs, bsbm_interp, bsbm_step.
//
// Use:
//   s_ side takes one request beat: s_tuser is op (0 square centre, 1 edge
//   midpoint pulled inward); s_tdata carries file, rank and edge direction.
//   m_ side returns one beat per request with the target x and y in steps.
//   Corners A1, H1, A8, H8 are written through the APB port (8 registers
//   at 4-byte spacing) while the block is idle; reads return them sign
//   extended.
// Pipeline: from input beat to output valid the stages are
//   3 interpolation stages, difference, square, sum-of-squares, 16 stages
//   of the push search (8 bits, 2 stages each) and the clamp/output stage.
// Throughput: one beat per cycle while m_tready is high, set by the fully
//   pipelined search; each stage holds a valid bit and moves when it or any
//   later stage has room, so bubbles close up under backpressure.
// Reset: valid bits and corner registers clear; corners read back as 0.
// Stall: a held result stays on m_tdata; earlier stages keep filling
//   until the pipe is full, then s_tready drops. Nothing is lost or doubled.
module board_square_bilinear_map (
    input  logic                    aclk,
    input  logic                    aresetn,
    // request: [2:0] file_index, [6:3] rank_number, [8:7] dir_x,
    // [10:9] dir_y, [15:11] zero
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,
    // [0] op
    input  logic                    s_tuser,
    // result: [23:0] pos_x, [47:24] pos_y
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [47:0]             m_tdata,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [bsbm_pkg::AW-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int ST_SRCH = 6;                         // first search stage
    localparam int NST     = ST_SRCH + 2 * bsbm_pkg::QW + 1;

    logic [NST-1:0]        vld_reg;
    logic [NST-1:0]        en;
    bsbm_pkg::corner_vec_t corners;
    bsbm_pkg::pts_t        pts;

    // stage 3: choose point, centre minus edge point
    logic                       op3_reg;
    bsbm_pkg::coord_t           ex3_reg, ey3_reg;
    logic signed [bsbm_pkg::DW-1:0] dx3_reg, dy3_reg;
    // stage 4: squares
    logic                       op4_reg;
    bsbm_pkg::coord_t           ex4_reg, ey4_reg;
    logic                       nx4_reg, ny4_reg;
    logic [bsbm_pkg::D2W-1:0]   dx2_reg, dy2_reg;
    logic signed [2*bsbm_pkg::DW-1:0] sqx, sqy;
    // stage 5 onward: search chain per axis
    logic [bsbm_pkg::SW-1:0]    s5;
    bsbm_pkg::srch_t            chx [bsbm_pkg::QW+1];
    bsbm_pkg::srch_t            chy [bsbm_pkg::QW+1];
    // output
    bsbm_pkg::coord_t           posx_reg, posy_reg;
    logic [bsbm_pkg::QW-1:0]    qx, qy;
    logic signed [25:0]         vx, vy;

    // A stage moves when any stage at or after it is empty, or output drains
    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_en
            assign en[k] = m_tready | ~(&vld_reg[NST-1:k]);
        end
    endgenerate

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {posy_reg, posx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    bsbm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .corners (corners)
    );

    bsbm_interp u_interp (
        .aclk     (aclk),
        .en_w     (en[0]),
        .en_p     (en[1]),
        .en_r     (en[2]),
        .op_in    (s_tuser),
        .file_in  (s_tdata[2:0]),
        .rank_in  (s_tdata[6:3]),
        .dir_x_in (s_tdata[8:7]),
        .dir_y_in (s_tdata[10:9]),
        .corners  (corners),
        .pts_reg  (pts)
    );

    // op 0 uses the centre itself; its push is suppressed later
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            op3_reg <= pts.op;
            ex3_reg <= pts.op ? pts.ex : pts.cx;
            ey3_reg <= pts.op ? pts.ey : pts.cy;
            dx3_reg <= bsbm_pkg::DW'(pts.cx) - bsbm_pkg::DW'(pts.ex);
            dy3_reg <= bsbm_pkg::DW'(pts.cy) - bsbm_pkg::DW'(pts.ey);
        end
    end

    assign sqx = dx3_reg * dx3_reg;
    assign sqy = dy3_reg * dy3_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            op4_reg <= op3_reg;
            ex4_reg <= ex3_reg;
            ey4_reg <= ey3_reg;
            nx4_reg <= dx3_reg[bsbm_pkg::DW-1];
            ny4_reg <= dy3_reg[bsbm_pkg::DW-1];
            dx2_reg <= sqx[bsbm_pkg::D2W-1:0];
            dy2_reg <= sqy[bsbm_pkg::D2W-1:0];
        end
    end

    // s = dx^2 + dy^2, w2 = (2*|d|*margin)^2 per axis
    assign s5 = bsbm_pkg::SW'(dx2_reg) + bsbm_pkg::SW'(dy2_reg);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            chx[0].push <= op4_reg && (s5 > bsbm_pkg::SW'(1));
            chx[0].neg  <= nx4_reg;
            chx[0].e    <= ex4_reg;
            chx[0].s    <= s5;
            chx[0].w2   <= bsbm_pkg::W2W'(dx2_reg) * bsbm_pkg::W2W'(bsbm_pkg::M2X4);
            chx[0].lo   <= '0;
            chx[0].a2   <= bsbm_pkg::K2W'(1);
            chy[0].push <= op4_reg && (s5 > bsbm_pkg::SW'(1));
            chy[0].neg  <= ny4_reg;
            chy[0].e    <= ey4_reg;
            chy[0].s    <= s5;
            chy[0].w2   <= bsbm_pkg::W2W'(dy2_reg) * bsbm_pkg::W2W'(bsbm_pkg::M2X4);
            chy[0].lo   <= '0;
            chy[0].a2   <= bsbm_pkg::K2W'(1);
        end
    end

    // Push search, most significant bit first
    genvar b;
    generate
        for (b = 0; b < bsbm_pkg::QW; b++) begin : g_srch
            bsbm_step #(.B(bsbm_pkg::QW - 1 - b)) u_step_x (
                .aclk  (aclk),
                .en_a  (en[ST_SRCH + 2*b]),
                .en_b  (en[ST_SRCH + 2*b + 1]),
                .d_in  (chx[b]),
                .d_reg (chx[b+1])
            );
            bsbm_step #(.B(bsbm_pkg::QW - 1 - b)) u_step_y (
                .aclk  (aclk),
                .en_a  (en[ST_SRCH + 2*b]),
                .en_b  (en[ST_SRCH + 2*b + 1]),
                .d_in  (chy[b]),
                .d_reg (chy[b+1])
            );
        end
    endgenerate

    // Apply push toward centre, then clamp to travel less stop distance
    always_comb begin
        qx = chx[bsbm_pkg::QW].push ? chx[bsbm_pkg::QW].lo : '0;
        qy = chy[bsbm_pkg::QW].push ? chy[bsbm_pkg::QW].lo : '0;
        vx = 26'(chx[bsbm_pkg::QW].e)
           + (chx[bsbm_pkg::QW].neg ? -26'(qx) : 26'(qx));
        vy = 26'(chy[bsbm_pkg::QW].e)
           + (chy[bsbm_pkg::QW].neg ? -26'(qy) : 26'(qy));
    end

    always_ff @(posedge aclk) begin
        if (en[NST-1]) begin
            posx_reg <= bsbm_pkg::clamp_out(vx, bsbm_pkg::X_LO_LIM, bsbm_pkg::X_HI_LIM);
            posy_reg <= bsbm_pkg::clamp_out(vy, bsbm_pkg::Y_LO_LIM, bsbm_pkg::Y_HI_LIM);
        end
    end

endmodule

FILE: hdl/bsbm_checker.sv
// Port-level checks for the board square mapper, bound to the top level.
// Depends on bsbm_pkg and board_square_bilinear_map.
module bsbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // no beat survives reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled beat stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    // stalled beat keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed under stall");

    // empty output means the pipe can take a request
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // results inside travel limits less stop distance
    a_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[23:0]) >= bsbm_pkg::X_LO_LIM)
                  && ($signed(m_tdata[23:0]) <= bsbm_pkg::X_HI_LIM)
                  && ($signed(m_tdata[47:24]) >= bsbm_pkg::Y_LO_LIM)
                  && ($signed(m_tdata[47:24]) <= bsbm_pkg::Y_HI_LIM))
        else $error("result outside travel limits");

endmodule

bind board_square_bilinear_map bsbm_checker u_bsbm_checker (.*);
